// ===== hw/rtl/u8dec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 forward decoder package
// Shared widths, the result word type and decoder constants.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    // Result queue behind the decode stage; a byte may push two words.
    localparam int RES_QUEUE_DEPTH = 4;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(21'h00FFFD);

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_replacement;
        logic            last_of_run;
    } u8dec_result_t;

endpackage

// ===== hw/rtl/u8dec_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder channels
// Valid/ready channels for raw bytes in and decoded code points out.
// ----------------------------------------------------------------------------
interface u8dec_byte_if
    import u8dec_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8dec_cp_if
    import u8dec_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            is_replacement;
    logic            last_of_run;

    modport source (output valid, output code_point, output is_replacement,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input is_replacement,
                    input last_of_run, output ready);
endinterface

// ===== hw/rtl/utf8_forward_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 forward decoder
// Decodes a byte stream into code points, U+FFFD on malformed input.
//
//   channel   dir  word                                      handshake
//   in_ch     in   data_byte[7:0]                            valid/ready
//   out_ch    out  code_point[20:0], is_replacement,         valid/ready
//                  last_of_run
//
// One byte per cycle: a byte is registered, decoded against the sequence
// state once the stage advances and its results land in a four-word result queue.
// A NUL inside a sequence yields two words, so the queue drains one word per cycle
// while out_ch is ready and sets the sustained rate when such bytes are frequent.
// Reset clears the sequence state, the stage and the queue; no warm-up.
// Input stalls only when the queue cannot take two more words.
// ----------------------------------------------------------------------------
module utf8_forward_decoder
    import u8dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    u8dec_byte_if.sink        in_ch,
    u8dec_cp_if.source        out_ch
);

    localparam int PTR_W = $clog2(RES_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(RES_QUEUE_DEPTH + 1);

    // input stage
    logic              stage_valid_reg;
    logic [BYTE_W-1:0] stage_byte_reg;

    // sequence state
    logic [CP_W-1:0]   partial_reg;
    logic [CP_W-1:0]   partial_next;
    logic [1:0]        pending_reg;
    logic [1:0]        pending_next;

    // result queue
    u8dec_result_t     queue_reg [RES_QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              advance;
    logic              in_fire;
    logic              pop;
    logic [1:0]        push_n;
    u8dec_result_t     res0;
    u8dec_result_t     res1;

    logic              is_ascii;
    logic              is_cont;
    logic              is_lead2;
    logic              is_lead3;
    logic              is_lead4;
    logic [BYTE_W-1:0] b;

    assign b        = stage_byte_reg;
    assign is_ascii = ~b[7];
    assign is_cont  = (b[7:6] == 2'b10);
    assign is_lead2 = (b[7:5] == 3'b110);
    assign is_lead3 = (b[7:4] == 4'b1110);
    assign is_lead4 = (b[7:3] == 5'b11110);

    // Advance only with room for the two-word case.
    assign advance  = stage_valid_reg &&
                      (count_reg <= CNT_W'(RES_QUEUE_DEPTH - 2));
    assign in_ch.ready = !stage_valid_reg || advance;
    assign in_fire  = in_ch.valid && in_ch.ready;

    assign out_ch.valid          = (count_reg != '0);
    assign out_ch.code_point     = queue_reg[rd_ptr_reg].code_point;
    assign out_ch.is_replacement = queue_reg[rd_ptr_reg].is_replacement;
    assign out_ch.last_of_run    = queue_reg[rd_ptr_reg].last_of_run;
    assign pop = out_ch.valid && out_ch.ready;

    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        push_n       = 2'd0;
        res0         = '{code_point: REPLACEMENT_CP, is_replacement: 1'b1,
                         last_of_run: 1'b1};
        res1         = '{code_point: '0, is_replacement: 1'b0, last_of_run: 1'b1};
        if (advance)
        begin
            if (pending_reg == 2'd0)
            begin
                if (is_ascii)
                begin
                    push_n = 2'd1;
                    res0   = '{code_point: CP_W'(b), is_replacement: 1'b0,
                               last_of_run: 1'b1};
                end
                else if (is_lead2)
                begin
                    partial_next = CP_W'(b[4:0]);
                    pending_next = 2'd1;
                end
                else if (is_lead3)
                begin
                    partial_next = CP_W'(b[3:0]);
                    pending_next = 2'd2;
                end
                else if (is_lead4)
                begin
                    partial_next = CP_W'(b[2:0]);
                    pending_next = 2'd3;
                end
                else
                begin
                    // stray continuation or five or more leading ones
                    push_n = 2'd1;
                end
            end
            else if (!is_cont)
            begin
                // drop the sequence; a NUL still comes through after U+FFFD
                partial_next = '0;
                pending_next = 2'd0;
                if (b == '0)
                begin
                    push_n = 2'd2;
                    res0.last_of_run = 1'b0;
                end
                else
                begin
                    push_n = 2'd1;
                end
            end
            else
            begin
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1)
                begin
                    push_n       = 2'd1;
                    partial_next = '0;
                    res0 = '{code_point: {partial_reg[CP_W-7:0], b[5:0]},
                             is_replacement: 1'b0, last_of_run: 1'b1};
                end
                else
                begin
                    partial_next = {partial_reg[CP_W-7:0], b[5:0]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            partial_reg     <= '0;
            pending_reg     <= 2'd0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                stage_valid_reg <= in_ch.valid;
            end
            partial_reg <= partial_next;
            pending_reg <= pending_next;
            wr_ptr_reg  <= wr_ptr_reg + PTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_byte_reg <= in_ch.data_byte;
        end
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    // Queue never overfills.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RES_QUEUE_DEPTH))
        else $error("result queue overflow");

    // A word that is not last of its run is a replacement with its partner queued.
    a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.last_of_run) |->
            (out_ch.is_replacement && count_reg >= CNT_W'(2)))
        else $error("split result pair");

    // A completed sequence leaves no partial value behind.
    a_partial_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 2'd0) |-> (partial_reg == '0))
        else $error("stale partial value");

    // Stage holds its byte while stalled.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=>
            (stage_valid_reg && $stable(stage_byte_reg)))
        else $error("stalled byte lost");

endmodule
